/* src/tse_pkg.sv */
// Shared types and constants for the topological sort engine.
package tse_pkg;

  // Fixed field widths of the channels
  localparam int VERTEX_W = 5;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 6;

  // Input transaction modes
  localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd2;

  // Vertex count after reset
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 6'd32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_POP,
    ST_SCAN,
    ST_EMIT
  } tse_state_t;

  // Commands from the sequencer to the adjacency bitmap
  typedef struct packed {
    logic                wr_en;
    logic                clr;
    logic [VERTEX_W-1:0] wr_row;
    logic [VERTEX_W-1:0] wr_col;
    logic [VERTEX_W-1:0] rd_row;
    logic [VERTEX_W-1:0] rd_col;
  } tse_adj_cmd_t;

endpackage

/* src/tse_channels.sv */
// Channel interfaces of the topological sort engine.
interface tse_in_if;
  logic                           valid;
  logic                           ready;
  logic [tse_pkg::MODE_W-1:0]     mode;
  logic [tse_pkg::VERTEX_W-1:0]   src_vertex;
  logic [tse_pkg::VERTEX_W-1:0]   dst_vertex;
  modport source (output valid, mode, src_vertex, dst_vertex, input ready);
  modport sink (input valid, mode, src_vertex, dst_vertex, output ready);
endinterface

interface tse_out_if;
  logic                           valid;
  logic                           ready;
  logic [tse_pkg::VERTEX_W-1:0]   vertex_id;
  logic                           cycle_found;
  logic                           last;
  modport source (output valid, vertex_id, cycle_found, last, input ready);
  modport sink (input valid, vertex_id, cycle_found, last, output ready);
endinterface

interface tse_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tse_pkg::COUNT_W-1:0]    vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

/* src/tse_adj_store.sv */
// Adjacency bitmap: one row per source vertex, one bit per destination.
module tse_adj_store #(
  parameter int NUM_V = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tse_pkg::tse_adj_cmd_t cmd,
  output logic                  rd_bit
);

  localparam int IW = $clog2(NUM_V);

  logic [NUM_V-1:0] rows_r [NUM_V];

  // Edge writes set one bit; a clear or reset wipes the whole bitmap at once.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      for (int i = 0; i < NUM_V; i++) begin
        rows_r[i] <= '0;
      end
    end else if (cmd.wr_en) begin
      rows_r[cmd.wr_row[IW-1:0]][cmd.wr_col[IW-1:0]] <= 1'b1;
    end
  end

  // Single read port: one bit of one row per cycle.
  assign rd_bit = rows_r[cmd.rd_row[IW-1:0]][cmd.rd_col[IW-1:0]];

endmodule

/* src/tse_seq.sv */
// Sequencer: in-degree count, ready queue walk and result emission.
module tse_seq #(
  parameter int NUM_V = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [$clog2(NUM_V+1)-1:0]       n_eff,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tse_pkg::MODE_W-1:0]       in_mode,
  input  logic [tse_pkg::VERTEX_W-1:0]     in_src,
  input  logic [tse_pkg::VERTEX_W-1:0]     in_dst,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tse_pkg::VERTEX_W-1:0]     out_vertex_id,
  output logic                             out_cycle_found,
  output logic                             out_last,
  output tse_pkg::tse_adj_cmd_t            adj_cmd,
  input  logic                             adj_bit
);

  localparam int IW = $clog2(NUM_V);
  localparam int CW = $clog2(NUM_V + 1);

  tse_pkg::tse_state_t state_r, state_nxt;

  logic [CW-1:0] v_r, v_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [CW-1:0] d_r, d_nxt;
  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [IW-1:0] cur_r, cur_nxt;

  logic [tse_pkg::VERTEX_W-1:0] vid_r, vid_nxt;
  logic                         cyc_r, cyc_nxt;
  logic                         last_r, last_nxt;

  // In-degree table and ready queue; the queue also holds the finished order.
  logic [CW-1:0] indeg_r [NUM_V];
  logic [IW-1:0] fifo_r [NUM_V];

  logic          indeg_we;
  logic [CW-1:0] indeg_wdata;
  logic          fifo_we;
  logic [IW-1:0] fifo_rd;
  logic [CW-1:0] fifo_raddr;
  logic [CW-1:0] indeg_rd;
  logic [CW-1:0] cnt;
  logic          in_fire;
  logic          w_last;
  logic          v_last;

  assign in_fire  = in_valid && in_ready;
  assign w_last   = (w_r + CW'(1)) == n_eff;
  assign v_last   = (v_r + CW'(1)) == n_eff;
  assign cnt      = d_r + CW'(adj_bit);
  assign indeg_rd = indeg_r[w_r[IW-1:0]];

  // Queue read address: the emit index while emitting, else the head, or entry zero once the queue is empty.
  always_comb begin
    if (state_r == tse_pkg::ST_EMIT) begin
      fifo_raddr = k_r;
    end else if (head_r == tail_r) begin
      fifo_raddr = '0;
    end else begin
      fifo_raddr = head_r;
    end
  end
  assign fifo_rd = fifo_r[fifo_raddr[IW-1:0]];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tse_pkg::ST_IDLE;
      v_r     <= '0;
      w_r     <= '0;
      d_r     <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      v_r     <= v_nxt;
      w_r     <= w_nxt;
      d_r     <= d_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      k_r     <= k_nxt;
    end
  end

  // Payload registers and tables
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    vid_r  <= vid_nxt;
    cyc_r  <= cyc_nxt;
    last_r <= last_nxt;
    if (indeg_we) begin
      indeg_r[w_r[IW-1:0]] <= indeg_wdata;
    end
    if (fifo_we) begin
      fifo_r[tail_r[IW-1:0]] <= w_r[IW-1:0];
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt   = state_r;
    v_nxt       = v_r;
    w_nxt       = w_r;
    d_nxt       = d_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    k_nxt       = k_r;
    cur_nxt     = cur_r;
    vid_nxt     = vid_r;
    cyc_nxt     = cyc_r;
    last_nxt    = last_r;
    indeg_we    = 1'b0;
    indeg_wdata = cnt;
    fifo_we     = 1'b0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    adj_cmd     = '0;
    adj_cmd.wr_row = in_src;
    adj_cmd.wr_col = in_dst;
    adj_cmd.rd_col = tse_pkg::VERTEX_W'(w_r);
    adj_cmd.rd_row = tse_pkg::VERTEX_W'(v_r);

    case (state_r)
      tse_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          case (in_mode)
            tse_pkg::MODE_EDGE: begin
              adj_cmd.wr_en = (6'(in_src) < 6'(n_eff)) && (6'(in_dst) < 6'(n_eff));
            end
            tse_pkg::MODE_CLEAR: begin
              adj_cmd.clr = 1'b1;
            end
            tse_pkg::MODE_RUN: begin
              v_nxt     = '0;
              w_nxt     = '0;
              d_nxt     = '0;
              head_nxt  = '0;
              tail_nxt  = '0;
              state_nxt = tse_pkg::ST_COUNT;
            end
            default: begin
            end
          endcase
        end
      end

      // Column w summed over rows v, one bit per cycle.
      tse_pkg::ST_COUNT: begin
        if (v_last) begin
          indeg_we    = 1'b1;
          indeg_wdata = cnt;
          if (cnt == '0 && tail_r < n_eff) begin
            fifo_we  = 1'b1;
            tail_nxt = tail_r + CW'(1);
          end
          d_nxt = '0;
          v_nxt = '0;
          if (w_last) begin
            w_nxt     = '0;
            state_nxt = tse_pkg::ST_POP;
          end else begin
            w_nxt = w_r + CW'(1);
          end
        end else begin
          v_nxt = v_r + CW'(1);
          d_nxt = cnt;
        end
      end

      // Take the next ready vertex, or finish the run.
      tse_pkg::ST_POP: begin
        if (head_r == tail_r) begin
          state_nxt = tse_pkg::ST_EMIT;
          if (tail_r == n_eff) begin
            vid_nxt  = tse_pkg::VERTEX_W'(fifo_rd);
            cyc_nxt  = 1'b0;
            last_nxt = (n_eff == CW'(1));
            k_nxt    = CW'(1);
          end else begin
            vid_nxt  = '0;
            cyc_nxt  = 1'b1;
            last_nxt = 1'b1;
          end
        end else begin
          cur_nxt   = fifo_rd;
          head_nxt  = head_r + CW'(1);
          w_nxt     = '0;
          state_nxt = tse_pkg::ST_SCAN;
        end
      end

      // Visit successors of the current vertex in index order.
      tse_pkg::ST_SCAN: begin
        adj_cmd.rd_row = tse_pkg::VERTEX_W'(cur_r);
        if (adj_bit && indeg_rd != '0) begin
          indeg_we    = 1'b1;
          indeg_wdata = indeg_rd - CW'(1);
          if (indeg_rd == CW'(1) && tail_r < n_eff) begin
            fifo_we  = 1'b1;
            tail_nxt = tail_r + CW'(1);
          end
        end
        if (w_last) begin
          state_nxt = tse_pkg::ST_POP;
        end else begin
          w_nxt = w_r + CW'(1);
        end
      end

      // Hand out the order, or the cycle report, one transaction at a time.
      tse_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last_r) begin
            state_nxt = tse_pkg::ST_IDLE;
          end else begin
            vid_nxt  = tse_pkg::VERTEX_W'(fifo_rd);
            last_nxt = (k_r + CW'(1)) == n_eff;
            k_nxt    = k_r + CW'(1);
          end
        end
      end

      default: begin
        state_nxt = tse_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_vertex_id   = vid_r;
  assign out_cycle_found = cyc_r;
  assign out_last        = last_r;

endmodule

/* src/topological_sort_engine_core.sv */
// Top level of the topological sort engine.
//
//  Channel  | Direction | Contents
//  in_chan  | sink      | mode, src_vertex, dst_vertex
//  out_chan | source    | vertex_id, cycle_found, last
//  cfg_chan | sink      | vertex_count (always ready)
//
// Edge and clear transactions are accepted whenever the engine is idle.
// A run first counts in-degrees and then walks the ready queue; the single read
// port of the adjacency bitmap, one bit per cycle, paces both phases.
// Results then leave one per cycle while out_chan is ready; input is held off
// until the last one is taken. Reset clears the bitmap and sets vertex_count to 32.
module topological_sort_engine_core #(
  parameter int MAX_VERTICES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  tse_in_if.sink    in_chan,
  tse_out_if.source out_chan,
  tse_cfg_if.sink   cfg_chan
);

  localparam int NV = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int CW = $clog2(NV + 1);
  localparam logic [tse_pkg::COUNT_W-1:0] NV_C = tse_pkg::COUNT_W'(NV);

  logic [tse_pkg::COUNT_W-1:0] vertex_count_r;
  logic [CW-1:0]               n_eff;
  tse_pkg::tse_adj_cmd_t       adj_cmd;
  logic                        adj_bit;

  // Configuration register
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= tse_pkg::VERTEX_COUNT_RESET;
    end else if (cfg_chan.valid) begin
      vertex_count_r <= cfg_chan.vertex_count;
    end
  end

  // Effective vertex count, kept between one and the bitmap size.
  always_comb begin
    if (vertex_count_r == '0) begin
      n_eff = CW'(1);
    end else if (vertex_count_r > NV_C) begin
      n_eff = CW'(NV);
    end else begin
      n_eff = CW'(vertex_count_r);
    end
  end

  tse_adj_store #(
    .NUM_V (NV)
  ) u_adj (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (adj_cmd),
    .rd_bit (adj_bit)
  );

  tse_seq #(
    .NUM_V (NV)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .n_eff           (n_eff),
    .in_valid        (in_chan.valid),
    .in_ready        (in_chan.ready),
    .in_mode         (in_chan.mode),
    .in_src          (in_chan.src_vertex),
    .in_dst          (in_chan.dst_vertex),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_vertex_id   (out_chan.vertex_id),
    .out_cycle_found (out_chan.cycle_found),
    .out_last        (out_chan.last),
    .adj_cmd         (adj_cmd),
    .adj_bit         (adj_bit)
  );

endmodule

/* src/tse_checker.sv */
// Port-level checks of the topological sort engine, bound to the top level.
module tse_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [tse_pkg::MODE_W-1:0]     in_mode,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tse_pkg::VERTEX_W-1:0]   out_vertex_id,
  input logic                           out_cycle_found,
  input logic                           out_last
);

  // A pending result holds until its transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_id) && $stable(out_last))
    else $error("result changed while stalled");

  // Input is never taken while results of a run are still going out.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during result emission");

  // A cycle report is a single final result with a zero vertex.
  a_cycle_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cycle_found |-> out_last && out_vertex_id == '0)
    else $error("malformed cycle report");

  // After the last result of a run, output goes quiet.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result after last");

  // A run transaction stalls the input while the sort works.
  a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == tse_pkg::MODE_RUN |=> !in_ready)
    else $error("input ready right after run");

endmodule

bind topological_sort_engine_core tse_checker u_tse_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_mode         (in_chan.mode),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_vertex_id   (out_chan.vertex_id),
  .out_cycle_found (out_chan.cycle_found),
  .out_last        (out_chan.last)
);
